/* design/kmnes_pkg.sv */
// Shared types and constants for the key matrix note event scanner.
// Used by every module of the block; depends on nothing.
package kmnes_pkg;

   localparam int COL_W       = 2;
   localparam int ROW_BITS    = 4;
   localparam int ROW_IDX_W   = 2;
   localparam int NOTE_W      = 7;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [NOTE_W-1:0] BASE_NOTE_RESET = 7'd60;
   localparam logic [NOTE_W-1:0] VELOCITY_ON     = 7'd127;
   localparam logic [NOTE_W-1:0] VELOCITY_OFF    = 7'd0;

   // One queued column sample: which rows changed and their new levels.
   typedef struct packed {
      logic [COL_W-1:0]    column;
      logic [ROW_BITS-1:0] change;
      logic [ROW_BITS-1:0] levels;
   } entry_type;

   // Index of the lowest set bit of a row change mask.
   function automatic logic [ROW_IDX_W-1:0] lowest_row(input logic [ROW_BITS-1:0] mask);
      logic [ROW_IDX_W-1:0] idx;
      idx = '0;
      if (mask[0]) begin
         idx = 2'd0;
      end else if (mask[1]) begin
         idx = 2'd1;
      end else if (mask[2]) begin
         idx = 2'd2;
      end else begin
         idx = 2'd3;
      end
      return idx;
   endfunction

endpackage

/* design/kmnes_front.sv */
// Front end: accepts column samples, compares them with the stored key levels,
// updates the levels and, while the link is up, queues the rows that changed. Depends on kmnes_pkg.
module kmnes_front #(
   parameter int COLUMNS = 4,
   parameter int ROWS    = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [kmnes_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                                req_tuser,
   input  logic                                queue_full,
   output logic                                push,
   output kmnes_pkg::entry_type                push_entry
);
   import kmnes_pkg::*;

   localparam int RS = (ROWS < ROW_BITS) ? ROWS : ROW_BITS;

   logic [COLUMNS-1:0][ROWS-1:0] key_levels_ff;
   logic [COLUMNS-1:0][ROWS-1:0] key_levels_in;
   logic [COL_W-1:0]             column_index;
   logic [ROW_BITS-1:0]          row_levels;
   logic [ROW_BITS-1:0]          old_rows;
   logic [ROW_BITS-1:0]          change;
   logic                         col_valid;
   logic                         accept;

   assign column_index = req_tdata[COL_W-1:0];
   assign row_levels   = req_tdata[COL_W+ROW_BITS-1:COL_W];
   assign req_tready   = !queue_full;
   assign accept       = req_tvalid && req_tready;

   always_comb begin
      old_rows  = '1;
      col_valid = 1'b0;
      for (int c = 0; c < COLUMNS; c++) begin
         if (32'(column_index) == c) begin
            col_valid = 1'b1;
            for (int r = 0; r < RS; r++) begin
               old_rows[r] = key_levels_ff[c][r];
            end
         end
      end
      change = '0;
      for (int r = 0; r < RS; r++) begin
         change[r] = col_valid && (row_levels[r] != old_rows[r]);
      end
   end

   always_comb begin
      key_levels_in = key_levels_ff;
      if (accept) begin
         for (int c = 0; c < COLUMNS; c++) begin
            if (32'(column_index) == c) begin
               for (int r = 0; r < RS; r++) begin
                  key_levels_in[c][r] = row_levels[r];
               end
            end
         end
      end
   end

   // Levels are tracked even when the link is down; only the events are dropped.
   assign push              = accept && req_tuser && (change != '0);
   assign push_entry.column = column_index;
   assign push_entry.change = change;
   assign push_entry.levels = row_levels;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_levels_ff <= '1;
      end else begin
         key_levels_ff <= key_levels_in;
      end
   end

endmodule

/* design/kmnes_queue.sv */
// Small register queue between the front and back ends of the scanner.
// Depends on kmnes_pkg for the entry type and depth.
module kmnes_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  kmnes_pkg::entry_type push_entry,
   input  logic                 pop,
   output kmnes_pkg::entry_type pop_entry,
   output logic                 full,
   output logic                 empty
);
   import kmnes_pkg::*;

   localparam logic [QPTR_W:0] DEPTH_COUNT = (QPTR_W+1)'(QUEUE_DEPTH);

   entry_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QPTR_W:0]   count_ff;
   logic [QPTR_W:0]   count_in;

   assign full      = (count_ff == DEPTH_COUNT);
   assign empty     = (count_ff == '0);
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* design/kmnes_back.sv */
// Back end: takes queued column samples and sends one note event per changed
// row, lowest row first, through a response register. Depends on kmnes_pkg.
module kmnes_back #(
   parameter int ROWS = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [kmnes_pkg::NOTE_W-1:0]     base_note,
   input  logic                             queue_empty,
   input  kmnes_pkg::entry_type             pop_entry,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [kmnes_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                             rsp_tuser,
   output logic                             rsp_tlast
);
   import kmnes_pkg::*;

   logic                    work_valid_ff;
   logic                    work_valid_in;
   entry_type               work_ff;
   entry_type               work_in;
   logic [ROW_IDX_W-1:0]    row;
   logic [ROW_BITS-1:0]     rest;
   logic                    last;
   logic                    emit;
   logic                    press;
   logic [NOTE_W-1:0]       note;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [NOTE_W-1:0]       rsp_note_ff;
   logic [NOTE_W-1:0]       rsp_velocity_ff;
   logic                    rsp_on_ff;
   logic                    rsp_last_ff;

   assign row   = lowest_row(work_ff.change);
   assign rest  = work_ff.change & ~(ROW_BITS'(1) << row);
   assign last  = (rest == '0);
   assign emit  = work_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign press = !work_ff.levels[row];
   assign note  = base_note + NOTE_W'(work_ff.column) * NOTE_W'(ROWS) + NOTE_W'(row);

   // The next sample loads in the same cycle the current one sends its last event.
   assign pop = !queue_empty && (!work_valid_ff || (emit && last));

   always_comb begin
      work_in       = work_ff;
      work_valid_in = work_valid_ff;
      if (pop) begin
         work_in       = pop_entry;
         work_valid_in = 1'b1;
      end else if (emit) begin
         work_in.change = rest;
         if (last) begin
            work_valid_in = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (emit) begin
         rsp_note_ff     <= note;
         rsp_velocity_ff <= press ? VELOCITY_ON : VELOCITY_OFF;
         rsp_on_ff       <= press;
         rsp_last_ff     <= last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-2*NOTE_W){1'b0}}, rsp_velocity_ff, rsp_note_ff};
   assign rsp_tuser  = rsp_on_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* design/key_matrix_note_event_scanner_unit.sv */
// Key matrix note event scanner: column samples in, note-on/off events out.
// Path: queue, work register, response register, in that order, to the first event.
// Throughput: one request per cycle in while the queue is not full; one response per
// cycle out while rsp_tready is high; a request yields one event per changed row.
// Reset: all keys released, base note 60, queue and response register empty.
module key_matrix_note_event_scanner_unit #(
   parameter int COLUMNS = 4,
   parameter int ROWS    = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [kmnes_pkg::REQ_DATA_W-1:0] req_tdata,  // column_index, row_levels
   input  logic                             req_tuser,  // link_ready
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [kmnes_pkg::RSP_DATA_W-1:0] rsp_tdata,  // note_number, velocity
   output logic                             rsp_tuser,  // note_on
   output logic                             rsp_tlast,  // last_event
   input  logic                             csr_wr_en,
   input  logic [kmnes_pkg::NOTE_W-1:0]     csr_wr_data // base_note
);
   import kmnes_pkg::*;

   logic [NOTE_W-1:0] base_note_ff;
   logic [NOTE_W-1:0] base_note_in;
   logic              push;
   logic              pop;
   logic              queue_full;
   logic              queue_empty;
   entry_type         push_entry;
   entry_type         pop_entry;

   assign base_note_in = csr_wr_en ? csr_wr_data : base_note_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_note_ff <= BASE_NOTE_RESET;
      end else begin
         base_note_ff <= base_note_in;
      end
   end

   kmnes_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   kmnes_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .full       (queue_full),
      .empty      (queue_empty)
   );

   kmnes_back #(
      .ROWS (ROWS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .base_note   (base_note_ff),
      .queue_empty (queue_empty),
      .pop_entry   (pop_entry),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule
